@@ rtl/spp_pkg.sv @@
package spp_pkg;

  localparam int CELLS     = 16;
  localparam int WORDS_DEF = 8;
  localparam int PERMS_DEF = 256;
  localparam int PERM_W    = 12;
  localparam int WORD_IW   = 6;
  localparam int DATA_W    = 64;
  localparam int CNT_W     = 10;
  localparam int SCORE_W   = 32;
  localparam int SIDE      = 513;
  localparam int TAW       = 19;

  localparam logic [CNT_W-1:0] CNT_MAX   = 10'd1023;
  localparam logic [CNT_W-1:0] INDEX_MAX = 10'd512;

  typedef enum logic [2:0] {
    ACT_LD_CASE  = 3'd0,
    ACT_LD_PERM  = 3'd1,
    ACT_LD_SCORE = 3'd2,
    ACT_PATH     = 3'd3,
    ACT_READ     = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    TOK_PATH    = 3'd0,
    TOK_FIN     = 3'd1,
    TOK_LDMASK  = 3'd2,
    TOK_LDSCORE = 3'd3,
    TOK_READ    = 3'd4,
    TOK_CLR     = 3'd5
  } tok_op_t;

  // One token travels down the cell chain per cycle.
  typedef struct packed {
    logic                valid;
    tok_op_t             op;
    logic [PERM_W-1:0]   perm;
    logic [WORD_IW-1:0]  word;
    logic [DATA_W-1:0]   d0;
    logic [DATA_W-1:0]   d1;
    logic [CNT_W-1:0]    tp;
    logic [CNT_W-1:0]    tn;
    logic [TAW-1:0]      taddr;
  } tok_t;

  function automatic logic [CNT_W-1:0] popcnt(input logic [DATA_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < DATA_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

endpackage

@@ rtl/spp_cell.sv @@
module spp_cell #(
  parameter int WORDS   = spp_pkg::WORDS_DEF,
  parameter int PPC     = 16,
  parameter int CELL_ID = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  spp_pkg::tok_t tok_i,
  output spp_pkg::tok_t tok_o
);
  import spp_pkg::*;

  localparam int KW     = (PPC > 1) ? $clog2(PPC) : 1;
  localparam int MDEPTH = WORDS * PPC;
  localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int TDEPTH = SIDE * SIDE;

  logic [DATA_W-1:0]  mask_mem [MDEPTH];
  logic [SCORE_W-1:0] tbl_mem  [TDEPTH];

  logic [CNT_W-1:0]   pc_r [PPC];
  logic [CNT_W-1:0]   nc_r [PPC];
  logic [SCORE_W-1:0] mx_r [PPC];

  tok_t               a_r, b_r, b_nxt;
  logic [DATA_W-1:0]  mask_q_r;
  logic [SCORE_W-1:0] score_q_r;

  logic [KW-1:0]      k_i, k_a;
  logic               mine_i, mine_a;
  logic [MAW-1:0]     maddr_i;
  logic [CNT_W:0]     cases_w, ctrls_w;
  logic [CNT_W-1:0]   cases, ctrls;
  logic [TAW-1:0]     fin_addr;

  always_comb begin
    k_i     = KW'(tok_i.perm % PPC);
    mine_i  = PERM_W'(tok_i.perm / PPC) == PERM_W'(CELL_ID);
    maddr_i = MAW'(int'(tok_i.word) * PPC + int'(k_i));
    k_a     = KW'(a_r.perm % PPC);
    mine_a  = PERM_W'(a_r.perm / PPC) == PERM_W'(CELL_ID);

    // Swapped counts of this slot, clamped to the table side.
    cases_w  = {1'b0, pc_r[k_i]} + {1'b0, sat_sub(tok_i.tn, nc_r[k_i])};
    ctrls_w  = {1'b0, nc_r[k_i]} + {1'b0, sat_sub(tok_i.tp, pc_r[k_i])};
    cases    = (cases_w > {1'b0, INDEX_MAX}) ? INDEX_MAX : cases_w[CNT_W-1:0];
    ctrls    = (ctrls_w > {1'b0, INDEX_MAX}) ? INDEX_MAX : ctrls_w[CNT_W-1:0];
    fin_addr = (TAW'(cases) << 9) + TAW'(cases) + TAW'(ctrls);
  end

  always_ff @(posedge clk) begin
    if (tok_i.valid && tok_i.op == TOK_LDMASK && mine_i) begin
      mask_mem[maddr_i] <= tok_i.d0;
    end
    mask_q_r <= mask_mem[maddr_i];
  end

  always_ff @(posedge clk) begin
    if (tok_i.valid && tok_i.op == TOK_LDSCORE) begin
      tbl_mem[tok_i.taddr] <= tok_i.d0[SCORE_W-1:0];
    end
    score_q_r <= tbl_mem[fin_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PPC; i++) begin
        pc_r[i] <= '0;
        nc_r[i] <= '0;
        mx_r[i] <= '0;
      end
    end else if (a_r.valid) begin
      case (a_r.op)
        TOK_PATH: begin
          pc_r[k_a] <= sat_add(pc_r[k_a], popcnt(a_r.d0 & mask_q_r));
          nc_r[k_a] <= sat_add(nc_r[k_a], popcnt(a_r.d1 & mask_q_r));
        end
        TOK_FIN: begin
          if (score_q_r > mx_r[k_a]) begin
            mx_r[k_a] <= score_q_r;
          end
          pc_r[k_a] <= '0;
          nc_r[k_a] <= '0;
        end
        TOK_CLR: begin
          for (int i = 0; i < PPC; i++) begin
            mx_r[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    b_nxt = a_r;
    if (a_r.valid && a_r.op == TOK_READ && mine_a) begin
      b_nxt.d0 = {{(DATA_W-SCORE_W){1'b0}}, mx_r[k_a]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
    end else begin
      a_r <= tok_i;
      b_r <= b_nxt;
    end
  end

  assign tok_o = b_r;

endmodule

@@ rtl/signed_path_permutation_scorer.sv @@
// Joins two signed path bitsets one 64-bit word per item and scores every
// permutation mask against the joined, conflict-free bits. The permutations
// are spread over a chain of up to 16 cells, each owning PPC slots (16 at the
// default sizes) with its own mask memory, count registers, maxima and copy of
// the score table; a token issued per slot walks the chain through two
// registers in each cell. A path word is tallied and its result sent; a valid
// word then issues a token per slot, and a last word adds a gap and a finish
// sweep. A maximum read waits for its token to leave the chain. No new item is
// taken before the last one is done. The joined words come back for every path
// word; the last word also carries the case and control counts.
module signed_path_permutation_scorer #(
  parameter int WORDS = spp_pkg::WORDS_DEF,
  parameter int PERMS = spp_pkg::PERMS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // word_index, perm_index, load_value, table_row, table_col,
  // first_pos, first_neg, second_pos, second_neg, zero pad
  input  logic [351:0] in_tdata,
  input  logic [2:0]   in_tuser,   // action
  input  logic         in_tlast,   // last_word
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_union, neg_union, out_word_index, case_count, control_count,
  // perm_max_score, zero pad
  output logic [183:0] out_tdata,
  output logic         out_tlast   // path_done
);
  import spp_pkg::*;

  localparam int PPC   = 2 ** $clog2((PERMS + CELLS - 1) / CELLS);
  localparam int NCELL = (PERMS + PPC - 1) / PPC;
  localparam int KW    = (PPC > 1) ? $clog2(PPC) : 1;
  localparam int CAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TALLY  = 7'b0000010,
    S_RESULT = 7'b0000100,
    S_PATH   = 7'b0001000,
    S_GAP    = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_WAIT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]   in_word;
  logic [7:0]   in_perm;
  logic [63:0]  in_val;
  logic [9:0]   in_row, in_col;
  logic [63:0]  in_fpos, in_fneg, in_spos, in_sneg;
  logic         in_fire;

  assign in_word = in_tdata[2:0];
  assign in_perm = in_tdata[10:3];
  assign in_val  = in_tdata[74:11];
  assign in_row  = in_tdata[84:75];
  assign in_col  = in_tdata[94:85];
  assign in_fpos = in_tdata[158:95];
  assign in_fneg = in_tdata[222:159];
  assign in_spos = in_tdata[286:223];
  assign in_sneg = in_tdata[350:287];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  logic [DATA_W-1:0] case_mem [WORDS];
  logic [DATA_W-1:0] cm_r;

  action_t            act_r;
  logic [2:0]         word_r;
  logic [DATA_W-1:0]  jpos_r, jneg_r;
  logic               last_r;
  logic [SCORE_W-1:0] rd_r, rd_nxt;
  logic [KW-1:0]      k_r, k_nxt;

  logic [CNT_W-1:0] tp_r, tn_r, pct_r, nct_r, pco_r, nco_r;
  logic [CNT_W-1:0] tp_nxt, tn_nxt, pct_nxt, nct_nxt, pco_nxt, nco_nxt;

  logic [DATA_W-1:0] only_pos, only_neg;
  logic              word_ok;

  tok_t tok_r, tok_nxt;
  tok_t chain [NCELL+1];

  logic         out_tvalid_r, out_tvalid_nxt;
  logic [183:0] out_tdata_r, out_tdata_nxt;
  logic         out_tlast_r, out_tlast_nxt;
  logic         out_free;

  assign only_pos = jpos_r & ~jneg_r;
  assign only_neg = jneg_r & ~jpos_r;
  assign word_ok  = 32'(word_r) < WORDS;
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (in_fire && in_tuser == ACT_LD_CASE && 32'(in_word) < WORDS) begin
      case_mem[CAW'(in_word)] <= in_val;
    end
    if (in_fire) begin
      cm_r <= case_mem[CAW'(in_word)];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= action_t'(in_tuser);
      word_r <= in_word;
      jpos_r <= in_fpos | in_spos;
      jneg_r <= in_fneg | in_sneg;
      last_r <= in_tlast;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    rd_nxt         = rd_r;
    tok_nxt        = '0;
    tp_nxt         = tp_r;
    tn_nxt         = tn_r;
    pct_nxt        = pct_r;
    nct_nxt        = nct_r;
    pco_nxt        = pco_r;
    nco_nxt        = nco_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          tok_nxt.perm = PERM_W'(in_perm);
          tok_nxt.word = WORD_IW'(in_word);
          tok_nxt.d0   = in_val;
          case (in_tuser)
            ACT_LD_PERM: begin
              tok_nxt.valid = (32'(in_word) < WORDS) && (32'(in_perm) < PERMS);
              tok_nxt.op    = TOK_LDMASK;
            end
            ACT_LD_SCORE: begin
              tok_nxt.valid = (in_row <= INDEX_MAX) && (in_col <= INDEX_MAX);
              tok_nxt.op    = TOK_LDSCORE;
              tok_nxt.taddr = (TAW'(in_row) << 9) + TAW'(in_row) + TAW'(in_col);
            end
            ACT_PATH: begin
              state_nxt = S_TALLY;
            end
            ACT_READ: begin
              if (32'(in_perm) < PERMS) begin
                tok_nxt.valid = 1'b1;
                tok_nxt.op    = TOK_READ;
                state_nxt     = S_WAIT;
              end else begin
                rd_nxt    = '0;
                state_nxt = S_RESULT;
              end
            end
            ACT_CLEAR: begin
              tok_nxt.valid = 1'b1;
              tok_nxt.op    = TOK_CLR;
            end
            default: ;
          endcase
        end
      end
      S_TALLY: begin
        if (word_ok) begin
          tp_nxt  = sat_add(tp_r, popcnt(only_pos));
          tn_nxt  = sat_add(tn_r, popcnt(only_neg));
          pct_nxt = sat_add(pct_r, popcnt(only_pos & cm_r));
          nct_nxt = sat_add(nct_r, popcnt(only_neg & ~cm_r));
          pco_nxt = sat_add(pco_r, popcnt(only_neg & cm_r));
          nco_nxt = sat_add(nco_r, popcnt(only_pos & ~cm_r));
        end
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = '0;
          out_tlast_nxt  = 1'b0;
          k_nxt          = '0;
          if (act_r == ACT_PATH) begin
            out_tdata_nxt[63:0]    = jpos_r;
            out_tdata_nxt[127:64]  = jneg_r;
            out_tdata_nxt[130:128] = word_r;
            if (last_r) begin
              out_tdata_nxt[140:131] = sat_add(pct_r, nct_r);
              out_tdata_nxt[150:141] = sat_add(pco_r, nco_r);
              out_tlast_nxt          = 1'b1;
            end
            if (word_ok) begin
              state_nxt = S_PATH;
            end else if (last_r) begin
              state_nxt = S_GAP;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            out_tdata_nxt[182:151] = rd_r;
            state_nxt              = S_IDLE;
          end
        end
      end
      S_PATH: begin
        tok_nxt.valid = 1'b1;
        tok_nxt.op    = TOK_PATH;
        tok_nxt.perm  = PERM_W'(k_r);
        tok_nxt.word  = WORD_IW'(word_r);
        tok_nxt.d0    = only_pos;
        tok_nxt.d1    = only_neg;
        k_nxt         = k_r + 1'b1;
        if (k_r == KW'(PPC - 1)) begin
          k_nxt     = '0;
          state_nxt = last_r ? S_GAP : S_IDLE;
        end
      end
      // One idle slot lets the last count update land before the finish sweep.
      S_GAP: begin
        k_nxt     = '0;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        tok_nxt.valid = 1'b1;
        tok_nxt.op    = TOK_FIN;
        tok_nxt.perm  = PERM_W'(k_r);
        tok_nxt.tp    = tp_r;
        tok_nxt.tn    = tn_r;
        k_nxt         = k_r + 1'b1;
        if (k_r == KW'(PPC - 1)) begin
          k_nxt     = '0;
          tp_nxt    = '0;
          tn_nxt    = '0;
          pct_nxt   = '0;
          nct_nxt   = '0;
          pco_nxt   = '0;
          nco_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_WAIT: begin
        if (chain[NCELL].valid && chain[NCELL].op == TOK_READ) begin
          rd_nxt    = chain[NCELL].d0[SCORE_W-1:0];
          state_nxt = S_RESULT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      k_r          <= '0;
      tok_r        <= '0;
      tp_r         <= '0;
      tn_r         <= '0;
      pct_r        <= '0;
      nct_r        <= '0;
      pco_r        <= '0;
      nco_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      tok_r        <= tok_nxt;
      tp_r         <= tp_nxt;
      tn_r         <= tn_nxt;
      pct_r        <= pct_nxt;
      nct_r        <= nct_nxt;
      pco_r        <= pco_nxt;
      nco_r        <= nco_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r        <= rd_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign chain[0] = tok_r;

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    spp_cell #(
      .WORDS  (WORDS),
      .PPC    (PPC),
      .CELL_ID(c)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .tok_i(chain[c]),
      .tok_o(chain[c+1])
    );
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

@@ tb/signed_path_permutation_scorer_test.sv @@
module signed_path_permutation_scorer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spp_pkg::*;

  localparam int NWORDS   = 8;
  localparam int NPERMS   = 256;
  localparam int TSIDE    = 513;
  localparam int BIT_CAP  = 24;    // surviving bits per path, keeps lookups inside loaded table
  localparam int N_RANDOM = 500;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [2:0]  action;
    logic [2:0]  word;
    logic [7:0]  perm;
    logic [63:0] value;
    logic [9:0]  row;
    logic [9:0]  col;
    logic [63:0] fpos;
    logic [63:0] fneg;
    logic [63:0] spos;
    logic [63:0] sneg;
    logic        last;
  } req_t;

  typedef struct {
    logic [63:0] jpos;
    logic [63:0] jneg;
    logic [2:0]  word;
    logic [9:0]  cases;
    logic [9:0]  ctrls;
    logic        done;
    logic [31:0] maxv;
  } res_t;

  typedef struct {
    req_t req;
    bit   typed;
    bit   has_res;
    res_t res;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [351:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [183:0] out_tdata;
  logic         out_tlast;

  signed_path_permutation_scorer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // Mirror of the scorer state.
  logic [63:0] case_words [NWORDS];
  logic [63:0] perm_mask [NWORDS][NPERMS];
  logic [31:0] score_tab [int];
  logic [31:0] perm_best [NPERMS];
  int          perm_pos_hits [NPERMS];
  int          perm_neg_hits [NPERMS];
  int          sum_pos, sum_neg, pos_case, neg_case, pos_ctrl, neg_ctrl;

  res_t pending_results[$];
  int   send_idle_pct, recv_idle_pct;
  int   mismatches;
  int   path_bits_used;

  function automatic int sat10(input int a, input int b);
    return (a + b > 1023) ? 1023 : a + b;
  endfunction

  function automatic int sub0(input int a, input int b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic int clamp512(input int v);
    return (v > 512) ? 512 : v;
  endfunction

  function automatic void clear_path_tallies();
    for (int r = 0; r < NPERMS; r++) begin
      perm_pos_hits[r] = 0;
      perm_neg_hits[r] = 0;
    end
    sum_pos = 0; sum_neg = 0;
    pos_case = 0; neg_case = 0; pos_ctrl = 0; neg_ctrl = 0;
  endfunction

  function automatic void score_item(input req_t q, output bit produced, output res_t e);
    logic [63:0] bp, bn, both, op, on, m, pm;
    int cases, ctrls, key;
    logic [31:0] s;
    produced = 0;
    e = '{default: '0};
    case (q.action)
      ACT_LD_CASE:  case_words[q.word] = q.value;
      ACT_LD_PERM:  perm_mask[q.word][q.perm] = q.value;
      ACT_LD_SCORE: begin
        if (q.row < TSIDE && q.col < TSIDE) score_tab[q.row * TSIDE + q.col] = q.value[31:0];
      end
      ACT_READ: begin
        produced = 1;
        e.maxv = perm_best[q.perm];
      end
      ACT_CLEAR: begin
        for (int r = 0; r < NPERMS; r++) perm_best[r] = '0;
      end
      ACT_PATH: begin
        produced = 1;
        bp = q.fpos | q.spos;
        bn = q.fneg | q.sneg;
        both = bp & bn;
        op = bp & ~both;
        on = bn & ~both;
        m = case_words[q.word];
        sum_pos  = sat10(sum_pos, $countones(op));
        sum_neg  = sat10(sum_neg, $countones(on));
        pos_case = sat10(pos_case, $countones(op & m));
        neg_case = sat10(neg_case, $countones(on & ~m));
        pos_ctrl = sat10(pos_ctrl, $countones(on & m));
        neg_ctrl = sat10(neg_ctrl, $countones(op & ~m));
        for (int r = 0; r < NPERMS; r++) begin
          pm = perm_mask[q.word][r];
          perm_pos_hits[r] = sat10(perm_pos_hits[r], $countones(op & pm));
          perm_neg_hits[r] = sat10(perm_neg_hits[r], $countones(on & pm));
        end
        e.jpos = bp;
        e.jneg = bn;
        e.word = q.word;
        if (q.last) begin
          e.cases = 10'(sat10(pos_case, neg_case));
          e.ctrls = 10'(sat10(pos_ctrl, neg_ctrl));
          e.done  = 1'b1;
          for (int r = 0; r < NPERMS; r++) begin
            cases = clamp512(perm_pos_hits[r] + sub0(sum_neg, perm_neg_hits[r]));
            ctrls = clamp512(perm_neg_hits[r] + sub0(sum_pos, perm_pos_hits[r]));
            key = cases * TSIDE + ctrls;
            s = score_tab.exists(key) ? score_tab[key] : '0;
            if (s > perm_best[r]) perm_best[r] = s;
          end
          clear_path_tallies();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [351:0] pack_req(input req_t q);
    return {1'b0, q.sneg, q.spos, q.fneg, q.fpos, q.col, q.row, q.value, q.perm, q.word};
  endfunction

  function automatic req_t blank_req(input logic [2:0] act);
    req_t q;
    q = '{default: '0};
    q.action = act;
    return q;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Noise in every field, then the fields that matter are set by the caller.
  function automatic req_t noisy_req(input logic [2:0] act);
    req_t q;
    q.action = act;
    q.word = 3'($urandom_range(7));
    q.perm = 8'($urandom_range(255));
    q.value = rand64();
    q.row = 10'($urandom_range(1023));
    q.col = 10'($urandom_range(1023));
    q.fpos = rand64(); q.fneg = rand64(); q.spos = rand64(); q.sneg = rand64();
    q.last = 1'($urandom_range(1));
    return q;
  endfunction

  // A path word whose surviving bits stay within the per-path budget. The
  // conflict bits appear in both joined halves and so never count.
  function automatic req_t path_word(input bit last);
    req_t q;
    logic [63:0] c, p, n, r1, r2;
    int want, bitpos;
    q = noisy_req(ACT_PATH);
    q.last = last;
    c = ($urandom_range(3) == 0) ? '0 : rand64();
    p = '0; n = '0;
    want = $urandom_range(6);
    if (want > BIT_CAP - path_bits_used) want = BIT_CAP - path_bits_used;
    for (int k = 0; k < want; k++) begin
      bitpos = $urandom_range(63);
      if (!c[bitpos] && !p[bitpos] && !n[bitpos]) begin
        if ($urandom_range(1)) p[bitpos] = 1'b1;
        else n[bitpos] = 1'b1;
      end
    end
    path_bits_used += $countones(p) + $countones(n);
    r1 = rand64(); r2 = rand64();
    q.fpos = (c & rand64()) | (p & r1);
    q.spos = c | (p & ~r1);
    q.fneg = (c & rand64()) | (n & r2);
    q.sneg = c | (n & ~r2);
    if (last) path_bits_used = 0;
    return q;
  endfunction

  task automatic send_item(input req_t q, input bit typed, input bit typed_has,
                           input res_t typed_res);
    bit   produced;
    res_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_req(q);
    in_tuser  <= q.action;
    in_tlast  <= q.last;
    do @(posedge clk); while (!in_tready);
    score_item(q, produced, e);
    if (typed) begin
      produced = typed_has;
      e = typed_res;
    end
    if (produced) pending_results.push_back(e);
  endtask

  task automatic send(input req_t q);
    send_item(q, 1'b0, 1'b0, '{default: '0});
  endtask

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
  endtask

  // Result side: check at the edge, then choose the next ready level.
  initial begin
    res_t e;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report("unexpected result", '0, out_tdata[63:0]);
        end else begin
          e = pending_results.pop_front();
          if (out_tdata[63:0] !== e.jpos) report("pos_union", e.jpos, out_tdata[63:0]);
          if (out_tdata[127:64] !== e.jneg) report("neg_union", e.jneg, out_tdata[127:64]);
          if (out_tdata[130:128] !== e.word) report("word_index", e.word, out_tdata[130:128]);
          if (out_tdata[140:131] !== e.cases) report("case_count", e.cases, out_tdata[140:131]);
          if (out_tdata[150:141] !== e.ctrls)
            report("control_count", e.ctrls, out_tdata[150:141]);
          if (out_tdata[182:151] !== e.maxv) report("perm_max_score", e.maxv, out_tdata[182:151]);
          if (out_tlast !== e.done) report("path_done", e.done, out_tlast);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ends the run if nothing moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("signed_path_permutation_scorer test failed");
        $finish;
      end
    end
  end

  dir_row_t dir_rows[$];

  task automatic add_row(input req_t q, input bit typed, input bit has_res, input res_t r);
    dir_row_t d;
    d.req = q; d.typed = typed; d.has_res = has_res; d.res = r;
    dir_rows.push_back(d);
  endtask

  initial begin
    req_t q;
    res_t r0, r;
    int pick;
    mismatches = 0;
    path_bits_used = 0;
    send_idle_pct = 27;
    recv_idle_pct = 56;
    for (int i = 0; i < NPERMS; i++) perm_best[i] = '0;
    clear_path_tallies();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_LD_CASE;
    in_tlast = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every mask and the part of the score table that paths can reach.
    for (int w = 0; w < NWORDS; w++) begin
      q = noisy_req(ACT_LD_CASE); q.word = 3'(w);
      send(q);
      for (int p = 0; p < NPERMS; p++) begin
        q = noisy_req(ACT_LD_PERM); q.word = 3'(w); q.perm = 8'(p);
        send(q);
      end
    end
    for (int a = 0; a <= BIT_CAP; a++) begin
      for (int b = 0; b <= BIT_CAP; b++) begin
        q = noisy_req(ACT_LD_SCORE); q.row = 10'(a); q.col = 10'(b);
        send(q);
      end
    end

    // Directed rows.
    r0 = '{default: '0};
    q = blank_req(ACT_READ);          add_row(q, 1, 1, r0);
    q = blank_req(ACT_READ); q.perm = 8'hFF; add_row(q, 1, 1, r0);
    q = blank_req(3'd6);              add_row(q, 1, 0, r0);
    q = noisy_req(3'd7);              add_row(q, 1, 0, r0);
    q = blank_req(ACT_CLEAR);         add_row(q, 1, 0, r0);
    q = blank_req(ACT_LD_SCORE); q.row = 10'h3FF; q.value = '1; add_row(q, 1, 0, r0);
    q = blank_req(ACT_LD_SCORE); q.col = 10'd513; q.value = '1; add_row(q, 1, 0, r0);
    // Every bit in conflict: joined halves all ones, nothing counts.
    q = blank_req(ACT_PATH); q.fpos = '1; q.sneg = '1; q.last = 1'b1;
    r = r0; r.jpos = '1; r.jneg = '1; r.done = 1'b1; add_row(q, 1, 1, r);
    q = blank_req(ACT_PATH); q.word = 3'd7; q.spos = '1; q.fneg = '1;
    r = r0; r.jpos = '1; r.jneg = '1; r.word = 3'd7; add_row(q, 1, 1, r);
    q = blank_req(ACT_PATH); q.word = 3'd3; q.fpos = 64'h8000_0000_0000_0001;
    q.sneg = 64'h0000_0100_0000_0000; q.last = 1'b1; add_row(q, 0, 0, r0);
    q = blank_req(ACT_READ); add_row(q, 0, 0, r0);
    q = blank_req(ACT_LD_SCORE); q.value = {32'h0, 32'hFFFF_FFFF}; add_row(q, 1, 0, r0);
    q = blank_req(ACT_LD_SCORE); q.row = 10'(BIT_CAP); q.col = 10'(BIT_CAP);
    q.value = '0; add_row(q, 1, 0, r0);
    // An empty path looks up the zero/zero entry for every permutation.
    q = blank_req(ACT_PATH); q.word = 3'd1; q.last = 1'b1;
    r = r0; r.word = 3'd1; r.done = 1'b1; add_row(q, 1, 1, r);
    q = blank_req(ACT_READ); q.perm = 8'd128;
    r = r0; r.maxv = 32'hFFFF_FFFF; add_row(q, 1, 1, r);
    q = blank_req(ACT_CLEAR); add_row(q, 1, 0, r0);
    q = blank_req(ACT_READ); q.perm = 8'd128; add_row(q, 1, 1, r0);
    q = blank_req(ACT_LD_PERM); q.word = 3'd7; q.perm = 8'hFF; q.value = '1;
    add_row(q, 1, 0, r0);
    q = blank_req(ACT_LD_CASE); q.word = 3'd7; add_row(q, 1, 0, r0);
    q = blank_req(ACT_PATH); q.word = 3'd7; q.spos = 64'h8000_0000_0000_0000;
    q.last = 1'b1; add_row(q, 0, 0, r0);
    q = blank_req(ACT_READ); q.perm = 8'hFF; add_row(q, 0, 0, r0);

    foreach (dir_rows[i])
      send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].has_res, dir_rows[i].res);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle_pct = 56; recv_idle_pct = 27;
      end else if (i == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (i == N_RANDOM / 2) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        q = path_word($urandom_range(2) == 0);
      end else if (pick < 70) begin
        q = noisy_req(ACT_READ);
      end else if (pick < 80) begin
        q = noisy_req(ACT_LD_SCORE);
        if ($urandom_range(3) != 0) begin
          q.row = 10'($urandom_range(BIT_CAP));
          q.col = 10'($urandom_range(BIT_CAP));
        end
      end else if (pick < 85) begin
        q = noisy_req(ACT_LD_CASE);
      end else if (pick < 91) begin
        q = noisy_req(ACT_LD_PERM);
      end else if (pick < 95) begin
        q = noisy_req(ACT_CLEAR);
      end else begin
        q = noisy_req(3'(6 + $urandom_range(1)));
      end
      send(q);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("signed_path_permutation_scorer test passed");
    end else begin
      $display("signed_path_permutation_scorer test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/spp_pkg.sv
rtl/spp_cell.sv
rtl/signed_path_permutation_scorer.sv
tb/signed_path_permutation_scorer_test.sv
